@@ src/variable_frame_ring_queue_assert.svh @@
// assertion macros shared by the ring queue modules
`ifndef VARIABLE_FRAME_RING_QUEUE_ASSERT_SVH
`define VARIABLE_FRAME_RING_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define VFRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfrq assertion failed");

// condition must hold in the cycle after the trigger
`define VFRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfrq assertion failed");

`else

`define VFRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define VFRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/vfrq_pkg.sv @@
`timescale 1ns / 1ps

package vfrq_pkg;

    // field widths
    localparam int OFS_W   = 11;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int STS_W   = 3;
    localparam int PLEFT_W = 7;
    localparam int SIZE_LSB = 16;
    localparam int SIZE_W   = 8;

    // store geometry, depth in words is a power of two
    localparam int STORE_BYTES  = 1024;
    localparam int HEADER_BYTES = 12;
    localparam int STORE_WORDS  = STORE_BYTES / 4;
    localparam int IDX_W        = $clog2(STORE_WORDS);

    // longest burst emitted by one pop
    localparam int MAX_OUT = 64;
    localparam int CNT_W   = $clog2(MAX_OUT);

    localparam logic [OFS_W-1:0] CAP_RESET = OFS_W'(1024);
    localparam logic [OFS_W-1:0] STORE_CAP =
        OFS_W'((STORE_BYTES > 2044) ? 2044 : STORE_BYTES);

    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL_END   = 3'd1,
        ST_FULL_FRONT = 3'd2,
        ST_ZERO_SIZE  = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_FIRST,
        S_POP_STREAM
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic query;
        logic push;
        logic pop_start;
        logic nop;
        logic pop_first;
        logic pop_stream;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic first_last;
        logic stream_last;
    } t_dp_sts;

    // placement test results
    typedef struct packed {
        logic ahead;
        logic end_ok;
        logic wrap_ok;
        logic front_ok;
    } t_fit;

    // header plus payload size, rounded up to whole words
    function automatic logic [OFS_W-1:0] footprint(input logic [WORD_W-1:0] w);
        logic [OFS_W-1:0] t;
        t = OFS_W'(HEADER_BYTES) + OFS_W'(w[SIZE_LSB +: SIZE_W]) + OFS_W'(3);
        return {t[OFS_W-1:2], 2'b00};
    endfunction

    // byte offset to word index, wrapping at the store depth
    function automatic logic [IDX_W-1:0] store_index(input logic [OFS_W-1:0] addr);
        logic [OFS_W-1:0] w;
        w = addr >> 2;
        return IDX_W'(w);
    endfunction

    // capacity with low bits cleared, limited to the store
    function automatic logic [OFS_W-1:0] eff_cap(input logic [OFS_W-1:0] cap);
        logic [OFS_W-1:0] c;
        c = {cap[OFS_W-1:2], 2'b00};
        return (c > STORE_CAP) ? STORE_CAP : c;
    endfunction

    function automatic t_fit fit_check(input logic [OFS_W-1:0] rd,
                                       input logic [OFS_W-1:0] wr,
                                       input logic [OFS_W-1:0] cap,
                                       input logic [OFS_W-1:0] size);
        t_fit       f;
        logic [OFS_W:0] sum;
        sum        = {1'b0, wr} + {1'b0, size};
        f.ahead    = (rd <= wr);
        f.end_ok   = (sum <= {1'b0, cap});
        f.wrap_ok  = (rd > size);
        f.front_ok = (sum < {1'b0, rd});
        return f;
    endfunction

endpackage

@@ src/variable_frame_ring_queue.sv @@
`timescale 1ns / 1ps

// channel      direction  handshake                 payload
// command      in         start high, busy low      i_op, i_word, i_query_bytes
// result       out        o_strobe, one cycle       o_status, o_fits, o_data_word, o_last
// config       in         i_cfg_valid, o_cfg_ready  i_cfg_data (capacity in bytes)
//
// query, push and undefined op: result on the next cycle, busy stays low
// pop of n words: busy high while the words stream out; the single
//   registered read port of the frame store delivers one word per cycle
// pop of an empty queue: answered like a query, busy stays low
// reset is synchronous, active low; frame store contents are undefined after it
// results cannot be stalled: each strobe lasts one cycle and must be taken

module variable_frame_ring_queue
    import vfrq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [WORD_W-1:0] i_word,
    input  logic [OFS_W-1:0]  i_query_bytes,
    output logic              o_strobe,
    output logic [STS_W-1:0]  o_status,
    output logic              o_fits,
    output logic [WORD_W-1:0] o_data_word,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [OFS_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config is taken whenever no frame is streaming
    assign o_cfg_ready = ~busy;

    vfrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    vfrq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word        (i_word),
        .i_query_bytes (i_query_bytes),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_sts         (sts),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_fits        (o_fits),
        .o_data_word   (o_data_word),
        .o_last        (o_last)
    );

endmodule

@@ src/vfrq_ram.sv @@
`timescale 1ns / 1ps

module vfrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/vfrq_ctrl.sv @@
`timescale 1ns / 1ps
`include "variable_frame_ring_queue_assert.svh"

module vfrq_ctrl
    import vfrq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  t_dp_sts         i_sts,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   take;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign take = i_start && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (take) begin
                    case (t_op'(i_op))
                        OP_QUERY: o_cmd.query = 1'b1;
                        OP_PUSH:  o_cmd.push  = 1'b1;
                        OP_POP: begin
                            o_cmd.pop_start = 1'b1;
                            if (!i_sts.empty) begin
                                n_state = S_POP_FIRST;
                            end
                        end
                        default:  o_cmd.nop   = 1'b1;
                    endcase
                end
            end
            S_POP_FIRST: begin
                o_cmd.pop_first = 1'b1;
                n_state = i_sts.first_last ? S_IDLE : S_POP_STREAM;
            end
            S_POP_STREAM: begin
                o_cmd.pop_stream = 1'b1;
                if (i_sts.stream_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a non-empty pop always goes on to fetch the front frame
    `VFRQ_ASSERT_NEXT(a_pop_enters, i_clk, i_rst_n, take && (i_op == OP_POP) && !i_sts.empty, r_state == S_POP_FIRST)
    // no new transaction is started while a frame streams out
    `VFRQ_ASSERT_NOW(a_busy_no_start, i_clk, i_rst_n, o_busy, !(o_cmd.query || o_cmd.push || o_cmd.pop_start || o_cmd.nop))

endmodule

@@ src/vfrq_dp.sv @@
`timescale 1ns / 1ps
`include "variable_frame_ring_queue_assert.svh"

module vfrq_dp
    import vfrq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [WORD_W-1:0] i_word,
    input  logic [OFS_W-1:0]  i_query_bytes,
    input  logic              i_cfg_we,
    input  logic [OFS_W-1:0]  i_cfg_data,
    output t_dp_sts           o_sts,
    output logic              o_strobe,
    output logic [STS_W-1:0]  o_status,
    output logic              o_fits,
    output logic [WORD_W-1:0] o_data_word,
    output logic              o_last
);

    // control state
    logic [OFS_W-1:0]   r_cap, n_cap;
    logic [OFS_W-1:0]   r_read_offset, n_read_offset;
    logic [OFS_W-1:0]   r_write_offset, n_write_offset;
    logic [OFS_W-1:0]   r_wrap_end, n_wrap_end;
    logic [PLEFT_W-1:0] r_push_left, n_push_left;
    logic [OFS_W-1:0]   r_push_addr, n_push_addr;
    logic               r_push_drop, n_push_drop;
    logic               r_pop_wrapped, n_pop_wrapped;
    logic [CNT_W-1:0]   r_pop_left, n_pop_left;
    logic               r_strobe, n_strobe;
    logic               r_last, n_last;

    // payload
    logic [IDX_W-1:0]   r_idx;
    logic [STS_W-1:0]   r_status, n_status;
    logic               r_fits, n_fits;
    logic [WORD_W-1:0]  r_data, n_data;

    // store access
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;
    logic [WORD_W-1:0]  rdata;

    // shared decode
    logic [OFS_W-1:0]   cap;
    logic [OFS_W-1:0]   fp_in;
    logic [OFS_W-1:0]   fp_pop;
    logic [OFS_W-3:0]   nwords;
    logic [OFS_W-1:0]   chk_size;
    t_fit               fit;
    logic               fit_ok;
    logic               wrapped;
    logic [OFS_W-1:0]   base;

    assign cap      = eff_cap(r_cap);
    assign fp_in    = footprint(i_word);
    assign fp_pop   = footprint(rdata);
    assign nwords   = fp_pop[OFS_W-1:2];
    assign chk_size = i_cmd.push ? fp_in : i_query_bytes;
    assign fit      = fit_check(r_read_offset, r_write_offset, cap, chk_size);
    assign fit_ok   = fit.ahead ? (fit.end_ok || fit.wrap_ok) : fit.front_ok;
    assign wrapped  = (r_read_offset >= r_wrap_end);
    assign base     = wrapped ? '0 : r_read_offset;

    // status to controller
    assign o_sts.empty       = (r_read_offset == r_write_offset);
    assign o_sts.first_last  = (nwords <= (OFS_W-2)'(1));
    assign o_sts.stream_last = (r_pop_left == CNT_W'(1));

    // read address: front frame base on a new pop, then the next word
    assign raddr = (i_cmd.pop_first || i_cmd.pop_stream) ? r_idx + IDX_W'(1)
                                                         : store_index(base);

    vfrq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // next-state logic for all commands
    always_comb begin
        n_cap          = r_cap;
        n_read_offset  = r_read_offset;
        n_write_offset = r_write_offset;
        n_wrap_end     = r_wrap_end;
        n_push_left    = r_push_left;
        n_push_addr    = r_push_addr;
        n_push_drop    = r_push_drop;
        n_pop_wrapped  = r_pop_wrapped;
        n_pop_left     = r_pop_left;
        n_strobe       = 1'b0;
        n_last         = 1'b0;
        n_status       = ST_OK;
        n_fits         = 1'b0;
        n_data         = '0;
        we             = 1'b0;
        waddr          = store_index(r_push_addr);

        if (i_cfg_we) begin
            n_cap = i_cfg_data;
        end

        // fit query and undefined op
        if (i_cmd.query || i_cmd.nop) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            n_fits   = i_cmd.query && fit_ok;
        end

        // push one frame word
        if (i_cmd.push) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            if (r_push_left != '0) begin
                // continuation word, stored or swallowed
                if (!r_push_drop) begin
                    we          = 1'b1;
                    n_push_addr = r_push_addr + OFS_W'(4);
                end
                n_push_left = r_push_left - PLEFT_W'(1);
            end else begin
                // first word: size the frame and place it
                n_push_left = (fp_in == '0) ? '0 : PLEFT_W'(fp_in >> 2) - PLEFT_W'(1);
                n_push_drop = 1'b1;
                if (i_word[SIZE_LSB +: SIZE_W] == '0) begin
                    n_status = ST_ZERO_SIZE;
                end else if (fit.ahead && fit.end_ok) begin
                    we             = 1'b1;
                    waddr          = store_index(r_write_offset);
                    n_push_addr    = r_write_offset + OFS_W'(4);
                    n_write_offset = r_write_offset + fp_in;
                    n_push_drop    = 1'b0;
                end else if (fit.ahead && fit.wrap_ok) begin
                    we             = 1'b1;
                    waddr          = '0;
                    n_wrap_end     = r_write_offset;
                    n_push_addr    = OFS_W'(4);
                    n_write_offset = fp_in;
                    n_push_drop    = 1'b0;
                end else if (fit.ahead) begin
                    n_status = ST_FULL_END;
                end else if (fit.front_ok) begin
                    we             = 1'b1;
                    waddr          = store_index(r_write_offset);
                    n_push_addr    = r_write_offset + OFS_W'(4);
                    n_write_offset = r_write_offset + fp_in;
                    n_push_drop    = 1'b0;
                end else begin
                    n_status = ST_FULL_FRONT;
                end
            end
        end

        // pop start: answer empty or latch where the frame sits
        if (i_cmd.pop_start) begin
            if (o_sts.empty) begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_status = ST_EMPTY;
            end else begin
                n_pop_wrapped = wrapped;
            end
        end

        // first word back: emit it, size the burst, move the front
        if (i_cmd.pop_first) begin
            n_strobe = 1'b1;
            n_data   = rdata;
            n_last   = o_sts.first_last;
            if (nwords > (OFS_W-2)'(MAX_OUT)) begin
                n_pop_left = CNT_W'(MAX_OUT - 1);
            end else if (nwords == '0) begin
                n_pop_left = '0;
            end else begin
                n_pop_left = CNT_W'(nwords - (OFS_W-2)'(1));
            end
            if (r_pop_wrapped) begin
                n_read_offset = fp_pop;
                n_wrap_end    = cap;
            end else begin
                n_read_offset = r_read_offset + fp_pop;
            end
        end

        // remaining words of the burst
        if (i_cmd.pop_stream) begin
            n_strobe   = 1'b1;
            n_data     = rdata;
            n_last     = o_sts.stream_last;
            n_pop_left = r_pop_left - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap          <= CAP_RESET;
            r_read_offset  <= '0;
            r_write_offset <= '0;
            r_wrap_end     <= eff_cap(CAP_RESET);
            r_push_left    <= '0;
            r_push_addr    <= '0;
            r_push_drop    <= 1'b0;
            r_pop_wrapped  <= 1'b0;
            r_pop_left     <= '0;
            r_strobe       <= 1'b0;
            r_last         <= 1'b0;
        end else begin
            r_cap          <= n_cap;
            r_read_offset  <= n_read_offset;
            r_write_offset <= n_write_offset;
            r_wrap_end     <= n_wrap_end;
            r_push_left    <= n_push_left;
            r_push_addr    <= n_push_addr;
            r_push_drop    <= n_push_drop;
            r_pop_wrapped  <= n_pop_wrapped;
            r_pop_left     <= n_pop_left;
            r_strobe       <= n_strobe;
            r_last         <= n_last;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= raddr;
        r_status <= n_status;
        r_fits   <= n_fits;
        r_data   <= n_data;
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_fits      = r_fits;
    assign o_data_word = r_data;
    assign o_last      = r_last;

    // offsets stay word aligned
    `VFRQ_ASSERT_NOW(a_ofs_align, i_clk, i_rst_n, 1'b1, (r_read_offset[1:0] == 2'b00) && (r_write_offset[1:0] == 2'b00) && (r_wrap_end[1:0] == 2'b00))
    // single-result transactions answer in the next cycle
    `VFRQ_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, i_cmd.query || i_cmd.push || i_cmd.nop, r_strobe && r_last)

endmodule

@@ tb/sv/tb_variable_frame_ring_queue.sv @@
`timescale 1ns / 1ps

module tb_variable_frame_ring_queue;
    import vfrq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_POPS  = 64;

    // one expected result transaction
    typedef struct {
        t_status           status;
        logic              fits;
        logic [WORD_W-1:0] data;
        logic              last;
    } t_ring_result;

    // block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op = '0;
    logic [WORD_W-1:0] i_word = '0;
    logic [OFS_W-1:0]  i_query_bytes = '0;
    logic              o_strobe;
    logic [STS_W-1:0]  o_status;
    logic              o_fits;
    logic [WORD_W-1:0] o_data_word;
    logic              o_last;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [OFS_W-1:0]  i_cfg_data = '0;

    // shadow of the ring state
    logic [OFS_W-1:0]   cap_reg = CAP_RESET;
    logic [OFS_W-1:0]   front_ofs = '0;
    logic [OFS_W-1:0]   back_ofs = '0;
    logic [OFS_W-1:0]   wrap_ofs = CAP_RESET;
    logic [WORD_W-1:0]  frame_mem [STORE_WORDS];
    bit                 frame_mem_set [STORE_WORDS];
    logic [PLEFT_W-1:0] words_due = '0;
    logic [OFS_W-1:0]   fill_ofs = '0;
    logic               fill_drop = 1'b0;

    t_ring_result pending_results [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           gaps_on = 1'b1;

    variable_frame_ring_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_word        (i_word),
        .i_query_bytes (i_query_bytes),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_fits        (o_fits),
        .o_data_word   (o_data_word),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // usable ring size: word aligned, limited to the store
    function automatic logic [OFS_W-1:0] eff_capacity();
        logic [OFS_W-1:0] c;
        c = cap_reg & ~OFS_W'(3);
        return (c > OFS_W'(STORE_BYTES)) ? OFS_W'(STORE_BYTES) : c;
    endfunction

    // bytes taken by a frame, from its first word
    function automatic logic [OFS_W-1:0] frame_bytes(input logic [WORD_W-1:0] w);
        logic [OFS_W-1:0] t;
        t = OFS_W'(HEADER_BYTES) + OFS_W'(w[SIZE_LSB +: SIZE_W]) + OFS_W'(3);
        return t & ~OFS_W'(3);
    endfunction

    function automatic logic [IDX_W-1:0] word_slot(input logic [OFS_W-1:0] ofs);
        return IDX_W'(ofs >> 2);
    endfunction

    function automatic int burst_len(input logic [OFS_W-1:0] bytes);
        int n;
        n = int'(bytes >> 2);
        if (n > MAX_OUT) n = MAX_OUT;
        if (n == 0) n = 1;
        return n;
    endfunction

    // where the front frame starts, taking an outstanding wrap into account
    function automatic logic [OFS_W-1:0] front_base();
        return (front_ofs >= wrap_ofs) ? '0 : front_ofs;
    endfunction

    function automatic void store_word(input logic [OFS_W-1:0] ofs,
                                       input logic [WORD_W-1:0] w);
        frame_mem[word_slot(ofs)]     = w;
        frame_mem_set[word_slot(ofs)] = 1'b1;
    endfunction

    // placement test for fit queries; push_status repeats it for first words
    function automatic logic room_for(input logic [OFS_W-1:0] bytes);
        if (front_ofs <= back_ofs)
            return (12'(back_ofs) + 12'(bytes) <= 12'(eff_capacity())) ||
                   (front_ofs > bytes);
        return 12'(back_ofs) + 12'(bytes) < 12'(front_ofs);
    endfunction

    function automatic void expect_result(input t_status st, input logic fits,
                                          input logic [WORD_W-1:0] data, input logic last);
        t_ring_result r;
        r.status = st;
        r.fits   = fits;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // push of one word: continuation, or first word with placement
    function automatic t_status push_status(input logic [WORD_W-1:0] w);
        logic [OFS_W-1:0] bytes;
        logic [OFS_W-1:0] base;
        t_status          st;
        if (words_due != 0) begin
            if (!fill_drop) begin
                store_word(fill_ofs, w);
                fill_ofs = fill_ofs + OFS_W'(4);
            end
            words_due = words_due - 1'b1;
            return ST_OK;
        end
        bytes     = frame_bytes(w);
        words_due = (bytes == 0) ? '0 : PLEFT_W'(bytes >> 2) - 1'b1;
        fill_drop = 1'b1;
        if (w[SIZE_LSB +: SIZE_W] == 0)
            return ST_ZERO_SIZE;
        st   = ST_OK;
        base = '0;
        if (front_ofs <= back_ofs) begin
            if (12'(back_ofs) + 12'(bytes) <= 12'(eff_capacity())) begin
                base     = back_ofs;
                back_ofs = back_ofs + bytes;
            end else if (front_ofs > bytes) begin
                // wrap to offset 0, remember where the old back was
                wrap_ofs = back_ofs;
                back_ofs = bytes;
            end else begin
                st = ST_FULL_END;
            end
        end else if (12'(back_ofs) + 12'(bytes) < 12'(front_ofs)) begin
            base     = back_ofs;
            back_ofs = back_ofs + bytes;
        end else begin
            st = ST_FULL_FRONT;
        end
        if (st == ST_OK) begin
            store_word(base, w);
            fill_ofs  = base + OFS_W'(4);
            fill_drop = 1'b0;
        end
        return st;
    endfunction

    // expected results of one accepted command, and the state it leaves
    function automatic void ring_predict(input t_op op, input logic [WORD_W-1:0] w,
                                         input logic [OFS_W-1:0] q);
        logic [OFS_W-1:0] base;
        logic [OFS_W-1:0] bytes;
        int               n;
        case (op)
            OP_QUERY: expect_result(ST_OK, room_for(q), '0, 1'b1);
            OP_PUSH:  expect_result(push_status(w), 1'b0, '0, 1'b1);
            OP_POP: begin
                if (front_ofs == back_ofs) begin
                    expect_result(ST_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    base  = front_base();
                    bytes = frame_bytes(frame_mem[word_slot(base)]);
                    n     = burst_len(bytes);
                    for (int k = 0; k < n; k++)
                        expect_result(ST_OK, 1'b0, frame_mem[word_slot(base + OFS_W'(4 * k))],
                                      k == n - 1);
                    // unwrap or advance by the whole frame
                    if (front_ofs >= wrap_ofs) begin
                        front_ofs = bytes;
                        wrap_ofs  = eff_capacity();
                    end else begin
                        front_ofs = front_ofs + bytes;
                    end
                end
            end
            default: expect_result(ST_OK, 1'b0, '0, 1'b1);
        endcase
    endfunction

    // a pop must never read a store word that was never written
    function automatic bit pop_reads_written();
        logic [OFS_W-1:0] base;
        int               n;
        if (front_ofs == back_ofs) return 1'b1;
        base = front_base();
        if (!frame_mem_set[word_slot(base)]) return 1'b0;
        n = burst_len(frame_bytes(frame_mem[word_slot(base)]));
        for (int k = 0; k < n; k++)
            if (!frame_mem_set[word_slot(base + OFS_W'(4 * k))]) return 1'b0;
        return 1'b1;
    endfunction

    // result checking, one transaction per strobe
    task automatic check_field(input string label, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_ring_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d data %h",
                         $time, o_status, o_data_word);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", WORD_W'(want.status), WORD_W'(o_status));
                check_field("fits", WORD_W'(want.fits), WORD_W'(o_fits));
                check_field("data_word", want.data, o_data_word);
                check_field("last", WORD_W'(want.last), WORD_W'(o_last));
            end
        end
    end

    // sender idle burst
    task automatic pause_burst();
        int n;
        n = $urandom_range(1, 17);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one command transaction; start stays high for a following command
    task automatic send_item(input t_op op, input logic [WORD_W-1:0] w,
                             input logic [OFS_W-1:0] q);
        if (!start) start <= 1'b1;
        i_op          <= op;
        i_word        <= w;
        i_query_bytes <= q;
        do @(posedge i_clk); while (busy);
        ring_predict(op, w, q);
        if (gaps_on && $urandom_range(0, 5) == 0) pause_burst();
    endtask

    // hold the sender until every expected result is in
    task automatic settle_queue();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [OFS_W-1:0] value);
        settle_queue();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [OFS_W-1:0] any_query();
        return OFS_W'($urandom_range(0, STORE_BYTES));
    endfunction

    // whole frame: first word with the given size byte, then its remaining words
    task automatic push_frame(input logic [SIZE_W-1:0] size_byte);
        logic [WORD_W-1:0] w;
        w = $urandom;
        w[SIZE_LSB +: SIZE_W] = size_byte;
        send_item(OP_PUSH, w, any_query());
        while (words_due != 0) send_item(OP_PUSH, $urandom, any_query());
    endtask

    // pop, or a query where the pop would read unwritten store words
    task automatic pop_or_query();
        if (pop_reads_written()) send_item(OP_POP, $urandom, any_query());
        else send_item(OP_QUERY, $urandom, any_query());
    endtask

    // finish any frame in flight and pop toward an empty ring, at most DRAIN_POPS pops
    task automatic drain_ring();
        int pops_left;
        pops_left = DRAIN_POPS;
        while (words_due != 0) send_item(OP_PUSH, $urandom, any_query());
        while (front_ofs != back_ofs && pops_left > 0 && pop_reads_written()) begin
            send_item(OP_POP, $urandom, any_query());
            pops_left--;
        end
    endtask

    // mostly small payloads, some empty, some long
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return SIZE_W'($urandom_range(245, 255));
        if (r < 30) return SIZE_W'($urandom_range(1, 255));
        return SIZE_W'($urandom_range(1, 40));
    endfunction

    // query sizes, half of them right at a placement boundary
    function automatic logic [OFS_W-1:0] pick_query();
        int v;
        if ($urandom_range(0, 1) == 0) return any_query();
        v = ($urandom_range(0, 1) == 0) ? int'(eff_capacity()) - int'(back_ofs)
                                        : int'(front_ofs);
        v = v + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > STORE_BYTES) v = STORE_BYTES;
        return OFS_W'(v);
    endfunction

    // frame sequences with random content, interleaved pops and queries
    task automatic random_traffic(input int budget);
        int                sent;
        int                pick;
        t_op               op;
        logic [WORD_W-1:0] w;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            w    = $urandom;
            if (words_due != 0)
                op = (pick < 80) ? OP_PUSH : (pick < 92) ? OP_POP :
                     (pick < 98) ? OP_QUERY : OP_NONE;
            else
                op = (pick < 45) ? OP_PUSH : (pick < 75) ? OP_POP :
                     (pick < 95) ? OP_QUERY : OP_NONE;
            if (op == OP_PUSH && words_due == 0) w[SIZE_LSB +: SIZE_W] = pick_size();
            if (op == OP_POP && !pop_reads_written()) op = OP_QUERY;
            send_item(op, w, pick_query());
            if (op != OP_NONE) sent++;
        end
    endtask

    // empty ring after reset: queries at both ends, empty pop, undefined op
    task automatic test_empty_queue();
        send_item(OP_QUERY, 32'hFFFF_FFFF, '0);
        send_item(OP_QUERY, '0, OFS_W'(STORE_BYTES));
        send_item(OP_POP, $urandom, any_query());
        send_item(OP_NONE, $urandom, any_query());
    endtask

    // zero payload size is flagged and its header words swallowed
    task automatic test_zero_size();
        send_item(OP_PUSH, '0, any_query());
        send_item(OP_PUSH, 32'hFFFF_FFFF, any_query());
        send_item(OP_PUSH, '0, any_query());
    endtask

    // small ring: full at end, wrap to offset 0, full before front, unwrap
    task automatic test_fill_and_wrap();
        write_capacity(OFS_W'(40));
        push_frame(8'd5);
        push_frame(8'd1);
        push_frame(8'd1);
        pop_or_query();
        push_frame(8'd1);
        push_frame(8'd1);
        send_item(OP_QUERY, $urandom, pick_query());
        pop_or_query();
        pop_or_query();
        pop_or_query();
    endtask

    // a frame longer than one pop burst, and one that just fits
    task automatic test_long_frame();
        drain_ring();
        write_capacity(OFS_W'(2047));
        push_frame(8'd255);
        pop_or_query();
        push_frame(8'd244);
        pop_or_query();
    endtask

    // random traffic over several ring sizes, the extremes among them
    task automatic test_random_phases();
        logic [OFS_W-1:0] caps [6] = '{11'd1023, 11'd64, 11'd4, 11'd256, 11'd2047, 11'd128};
        foreach (caps[i]) begin
            drain_ring();
            write_capacity(caps[i]);
            random_traffic((caps[i] == 11'd4) ? 10 : 25);
        end
    endtask

    // back to the reset size, back-to-back commands with no idling
    task automatic test_quiet_tail();
        drain_ring();
        write_capacity(CAP_RESET);
        gaps_on = 1'b0;
        random_traffic(30);
    endtask

    // reset, then the tests in turn
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_zero_size();
        test_fill_and_wrap();
        test_long_frame();
        test_random_phases();
        test_quiet_tail();
        settle_queue();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ variable_frame_ring_queue.f @@
+incdir+src
src/vfrq_pkg.sv
src/vfrq_ram.sv
src/vfrq_ctrl.sv
src/vfrq_dp.sv
src/variable_frame_ring_queue.sv
tb/sv/tb_variable_frame_ring_queue.sv
